>>> rtl/mips_rtype_execute_unit_assert.svh
// Assertion macros for the MIPS R-type execute unit.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef MIPS_RTYPE_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_RTYPE_EXECUTE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define MRE_ASSERT_IMPL(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MRE_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MRE_ASSERT_IMPL(name, ck, rn, ante, cons)
`define MRE_ASSERT_NEXT(name, ck, rn, ante, cons)

`endif

`endif

>>> rtl/mre_pkg.sv
// Shared types and constants for the MIPS R-type execute unit.
// No dependencies; used by the interfaces and all RTL modules.
package mre_pkg;

    localparam int XLEN         = 32;
    localparam int NUM_REGS_DEF = 32;
    localparam int REG_IDX_W    = 5;
    localparam int STATUS_W     = 2;
    localparam int FN_W         = 6;
    localparam int OPC_W        = 6;
    localparam int SHAMT_W      = 5;

    // function codes of the R-type group
    localparam logic [FN_W-1:0] FN_SLL   = 6'h00;
    localparam logic [FN_W-1:0] FN_SRL   = 6'h02;
    localparam logic [FN_W-1:0] FN_SRA   = 6'h03;
    localparam logic [FN_W-1:0] FN_JR    = 6'h08;
    localparam logic [FN_W-1:0] FN_MFHI  = 6'h10;
    localparam logic [FN_W-1:0] FN_MFLO  = 6'h12;
    localparam logic [FN_W-1:0] FN_MULT  = 6'h18;
    localparam logic [FN_W-1:0] FN_MULTU = 6'h19;
    localparam logic [FN_W-1:0] FN_DIV   = 6'h1a;
    localparam logic [FN_W-1:0] FN_DIVU  = 6'h1b;
    localparam logic [FN_W-1:0] FN_ADD   = 6'h20;
    localparam logic [FN_W-1:0] FN_ADDU  = 6'h21;
    localparam logic [FN_W-1:0] FN_SUB   = 6'h22;
    localparam logic [FN_W-1:0] FN_SUBU  = 6'h23;
    localparam logic [FN_W-1:0] FN_AND   = 6'h24;
    localparam logic [FN_W-1:0] FN_OR    = 6'h25;
    localparam logic [FN_W-1:0] FN_XOR   = 6'h26;
    localparam logic [FN_W-1:0] FN_NOR   = 6'h27;
    localparam logic [FN_W-1:0] FN_SLT   = 6'h2a;
    localparam logic [FN_W-1:0] FN_SLTU  = 6'h2b;

    localparam logic [OPC_W-1:0] OPC_RTYPE = 6'h00;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FUNCT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_RTYPE = 2'd2;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_MULDIV,
        CS_COMMIT
    } core_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } md_state_t;

    // request from the sequencer to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
        logic is_signed;
    } md_ctl_t;

endpackage

>>> rtl/mre_stream_if.sv
// Valid/ready channel interfaces for instruction words and execute results.
// Depends on mre_pkg for field widths.
interface mre_instr_if;
    logic                      valid;
    logic                      ready;
    logic [mre_pkg::XLEN-1:0]  instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface mre_result_if;
    logic                          valid;
    logic                          ready;
    logic [mre_pkg::XLEN-1:0]      next_pc;
    logic                          reg_write;
    logic [mre_pkg::REG_IDX_W-1:0] write_index;
    logic [mre_pkg::XLEN-1:0]      write_value;
    logic [mre_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output next_pc, output reg_write, output write_index,
                    output write_value, output status, input ready);
    modport sink   (input valid, input next_pc, input reg_write, input write_index,
                    input write_value, input status, output ready);
endinterface

>>> rtl/mre_regfile.sv
// General register file: two registered read ports, one write port.
// Depends on mre_pkg. Per-entry valid bits give the all-zero reset value.
module mre_regfile #(
    parameter int NUM_REGS = mre_pkg::NUM_REGS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(NUM_REGS)-1:0] rd_addr_a,
    input  logic [$clog2(NUM_REGS)-1:0] rd_addr_b,
    output logic [mre_pkg::XLEN-1:0]    rd_data_a,
    output logic [mre_pkg::XLEN-1:0]    rd_data_b,
    input  logic                        wr_en,
    input  logic [$clog2(NUM_REGS)-1:0] wr_addr,
    input  logic [mre_pkg::XLEN-1:0]    wr_data
);
    import mre_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    logic [XLEN-1:0]     mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [XLEN-1:0]     data_a_reg;
    logic [XLEN-1:0]     data_b_reg;
    logic                hit_a_reg;
    logic                hit_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= mem[rd_addr_b];
        end
    end

    // register zero and never-written entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_a_reg <= valid_reg[rd_addr_a] && (rd_addr_a != AW'(0));
                hit_b_reg <= valid_reg[rd_addr_b] && (rd_addr_b != AW'(0));
            end
        end
    end

    assign rd_data_a = hit_a_reg ? data_a_reg : '0;
    assign rd_data_b = hit_b_reg ? data_b_reg : '0;

endmodule

>>> rtl/mre_muldiv.sv
// Iterative multiply/divide unit built around one shared 34-bit adder.
// Depends on mre_pkg and the assertion macro header.
`include "mips_rtype_execute_unit_assert.svh"

module mre_muldiv (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mre_pkg::md_ctl_t         ctl,
    input  logic [mre_pkg::XLEN-1:0] op_a,
    input  logic [mre_pkg::XLEN-1:0] op_b,
    output logic                     done,
    output logic [mre_pkg::XLEN-1:0] hi,
    output logic [mre_pkg::XLEN-1:0] lo
);
    import mre_pkg::*;

    localparam int CW = $clog2(XLEN);
    localparam int AW = XLEN + 2;

    md_state_t           state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [2*XLEN-1:0]   acc_reg, acc_next;
    logic [XLEN-1:0]     mb_reg, mb_next;
    logic                div_reg, div_next;
    logic                neg_q_reg, neg_q_next;
    logic                neg_r_reg, neg_r_next;

    logic                neg_a;
    logic                neg_b;
    logic [XLEN-1:0]     mag_a;
    logic [XLEN-1:0]     mag_b;
    logic [AW-1:0]       add_x;
    logic [AW-1:0]       add_y;
    logic [AW-1:0]       add_sum;
    logic [2*XLEN-1:0]   prod_neg;
    logic [XLEN-1:0]     quo;
    logic [XLEN-1:0]     rem;

    assign neg_a = ctl.is_signed && op_a[XLEN-1];
    assign neg_b = ctl.is_signed && op_b[XLEN-1];
    assign mag_a = neg_a ? (XLEN'(0) - op_a) : op_a;
    assign mag_b = neg_b ? (XLEN'(0) - op_b) : op_b;

    // multiply: conditional add into the upper half, then shift right
    // divide: trial subtract of the divisor from the shifted remainder
    assign add_x   = div_reg ? {1'b0, acc_reg[2*XLEN-1:XLEN-1]}
                             : {2'b00, acc_reg[2*XLEN-1:XLEN]};
    assign add_y   = div_reg ? ~{2'b00, mb_reg}
                             : (acc_reg[0] ? {2'b00, mb_reg} : '0);
    assign add_sum = add_x + add_y + AW'(div_reg);

    assign prod_neg = (2*XLEN)'(0) - acc_reg;
    assign quo      = acc_reg[XLEN-1:0];
    assign rem      = acc_reg[2*XLEN-1:XLEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mb_reg    <= mb_next;
        div_reg   <= div_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mb_next    = mb_reg;
        div_next   = div_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        done       = 1'b0;
        hi         = '0;
        lo         = '0;
        case (state_reg)
            MD_IDLE:
            begin
                if (ctl.start)
                begin
                    acc_next   = {{XLEN{1'b0}}, mag_a};
                    mb_next    = mag_b;
                    div_next   = ctl.is_div;
                    neg_q_next = neg_a ^ neg_b;
                    neg_r_next = neg_a;
                    cnt_next   = '0;
                    state_next = MD_RUN;
                end
            end
            MD_RUN:
            begin
                if (div_reg)
                begin
                    if (!add_sum[AW-1])
                    begin
                        acc_next = {add_sum[XLEN-1:0], acc_reg[XLEN-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = {acc_reg[2*XLEN-2:0], 1'b0};
                    end
                end
                else
                begin
                    acc_next = {add_sum[XLEN:0], acc_reg[XLEN-1:1]};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(XLEN - 1))
                begin
                    state_next = MD_FIX;
                end
            end
            MD_FIX:
            begin
                done = 1'b1;
                if (div_reg)
                begin
                    hi = neg_r_reg ? (XLEN'(0) - rem) : rem;
                    lo = neg_q_reg ? (XLEN'(0) - quo) : quo;
                end
                else if (neg_q_reg)
                begin
                    hi = prod_neg[2*XLEN-1:XLEN];
                    lo = prod_neg[XLEN-1:0];
                end
                else
                begin
                    hi = rem;
                    lo = quo;
                end
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    `MRE_ASSERT_IMPL(a_md_start_idle, clk, rst_n, ctl.start, state_reg == MD_IDLE)
    `MRE_ASSERT_NEXT(a_md_done_idle, clk, rst_n, done, state_reg == MD_IDLE)
    `MRE_ASSERT_IMPL(a_md_run_count, clk, rst_n,
        (state_reg == MD_RUN) && ($past(state_reg) == MD_IDLE), cnt_reg == '0)

endmodule

>>> rtl/mips_rtype_execute_unit.sv
// MIPS32 R-type execute unit: instruction in, one result transaction out per instruction.
// Depends on mre_pkg, mre_stream_if, mre_regfile, mre_muldiv and the assertion header.
//
// Executes one instruction at a time under a four-state sequencer. An instruction is
// accepted when the unit is idle; the register file read is registered at acceptance,
// the next cycle decodes and runs the ALU or shifter, and the one after commits the
// register write, PC and result into the output register. mult, multu, div and divu run
// through the shared iterative multiply/divide unit (32 add or trial-subtract steps
// plus a sign fix-up step); divide by zero skips the unit and leaves HI/LO alone. The
// output register lets the next instruction be accepted while the previous result still
// waits; commit holds only while that register is full and not being read.
`include "mips_rtype_execute_unit_assert.svh"

module mips_rtype_execute_unit #(
    parameter int NUM_REGS = mre_pkg::NUM_REGS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mre_instr_if.sink     instr,
    mre_result_if.source  result
);
    import mre_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    core_state_t            state_reg, state_next;
    logic [XLEN-1:0]        instr_reg, instr_next;
    logic [XLEN-1:0]        pc_reg, pc_next;
    logic [XLEN-1:0]        hi_reg, hi_next;
    logic [XLEN-1:0]        lo_reg, lo_next;

    logic [XLEN-1:0]        res_npc_reg, res_npc_next;
    logic                   res_wr_reg, res_wr_next;
    logic [REG_IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic [XLEN-1:0]        res_val_reg, res_val_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;

    logic                   out_valid_reg, out_valid_next;
    logic [XLEN-1:0]        out_npc_reg, out_npc_next;
    logic                   out_wr_reg, out_wr_next;
    logic [REG_IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [XLEN-1:0]        out_val_reg, out_val_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    logic                   in_ready;
    logic                   rf_rd_en;
    logic                   rf_wr_en;
    logic [XLEN-1:0]        rf_a;
    logic [XLEN-1:0]        rf_b;

    md_ctl_t                md_ctl;
    logic                   md_done;
    logic [XLEN-1:0]        md_hi;
    logic [XLEN-1:0]        md_lo;

    logic [OPC_W-1:0]       ex_opc;
    logic [REG_IDX_W-1:0]   ex_rd;
    logic [SHAMT_W-1:0]     ex_sh;
    logic [FN_W-1:0]        ex_fn;
    logic                   ex_wr;
    logic [XLEN-1:0]        ex_val;
    logic [XLEN-1:0]        ex_npc;
    logic [STATUS_W-1:0]    ex_status;
    logic                   ex_md_go;
    logic                   ex_md_div;
    logic                   ex_md_signed;

    mre_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rf_rd_en),
        .rd_addr_a (AW'(instr.instruction[25:21])),
        .rd_addr_b (AW'(instr.instruction[20:16])),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr_en     (rf_wr_en),
        .wr_addr   (AW'(res_idx_reg)),
        .wr_data   (res_val_reg)
    );

    mre_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (md_ctl),
        .op_a  (rf_a),
        .op_b  (rf_b),
        .done  (md_done),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    assign ex_opc = instr_reg[31:26];
    assign ex_rd  = instr_reg[15:11];
    assign ex_sh  = instr_reg[10:6];
    assign ex_fn  = instr_reg[5:0];

    // decode and combinational ALU/shifter
    always_comb
    begin
        ex_wr        = 1'b0;
        ex_val       = '0;
        ex_npc       = pc_reg + XLEN'(4);
        ex_status    = STATUS_OK;
        ex_md_go     = 1'b0;
        ex_md_div    = 1'b0;
        ex_md_signed = 1'b0;
        if (ex_opc != OPC_RTYPE)
        begin
            ex_status = STATUS_NOT_RTYPE;
        end
        else
        begin
            case (ex_fn)
                FN_ADD, FN_ADDU:
                begin
                    ex_val = rf_a + rf_b;
                    ex_wr  = 1'b1;
                end
                FN_SUB, FN_SUBU:
                begin
                    ex_val = rf_a - rf_b;
                    ex_wr  = 1'b1;
                end
                FN_AND:
                begin
                    ex_val = rf_a & rf_b;
                    ex_wr  = 1'b1;
                end
                FN_OR:
                begin
                    ex_val = rf_a | rf_b;
                    ex_wr  = 1'b1;
                end
                FN_XOR:
                begin
                    ex_val = rf_a ^ rf_b;
                    ex_wr  = 1'b1;
                end
                FN_NOR:
                begin
                    ex_val = ~(rf_a | rf_b);
                    ex_wr  = 1'b1;
                end
                FN_SLT:
                begin
                    ex_val = XLEN'($signed(rf_a) < $signed(rf_b));
                    ex_wr  = 1'b1;
                end
                FN_SLTU:
                begin
                    ex_val = XLEN'(rf_a < rf_b);
                    ex_wr  = 1'b1;
                end
                FN_SLL:
                begin
                    ex_val = rf_b << ex_sh;
                    ex_wr  = 1'b1;
                end
                FN_SRL:
                begin
                    ex_val = rf_b >> ex_sh;
                    ex_wr  = 1'b1;
                end
                FN_SRA:
                begin
                    ex_val = XLEN'($signed(rf_b) >>> ex_sh);
                    ex_wr  = 1'b1;
                end
                FN_JR:
                begin
                    ex_npc = rf_a;
                end
                FN_MFHI:
                begin
                    ex_val = hi_reg;
                    ex_wr  = 1'b1;
                end
                FN_MFLO:
                begin
                    ex_val = lo_reg;
                    ex_wr  = 1'b1;
                end
                FN_MULT:
                begin
                    ex_md_go     = 1'b1;
                    ex_md_signed = 1'b1;
                end
                FN_MULTU:
                begin
                    ex_md_go = 1'b1;
                end
                FN_DIV:
                begin
                    ex_md_go     = (rf_b != '0);
                    ex_md_div    = 1'b1;
                    ex_md_signed = 1'b1;
                end
                FN_DIVU:
                begin
                    ex_md_go  = (rf_b != '0);
                    ex_md_div = 1'b1;
                end
                default:
                begin
                    ex_status = STATUS_BAD_FUNCT;
                end
            endcase
        end
    end

    assign md_ctl.start     = (state_reg == CS_EXEC) && ex_md_go;
    assign md_ctl.is_div    = ex_md_div;
    assign md_ctl.is_signed = ex_md_signed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            pc_reg        <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            res_wr_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            res_wr_reg    <= res_wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg      <= instr_next;
        res_npc_reg    <= res_npc_next;
        res_idx_reg    <= res_idx_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        out_npc_reg    <= out_npc_next;
        out_wr_reg     <= out_wr_next;
        out_idx_reg    <= out_idx_next;
        out_val_reg    <= out_val_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        instr_next      = instr_reg;
        pc_next         = pc_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        res_npc_next    = res_npc_reg;
        res_wr_next     = res_wr_reg;
        res_idx_next    = res_idx_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_npc_next    = out_npc_reg;
        out_wr_next     = out_wr_reg;
        out_idx_next    = out_idx_reg;
        out_val_next    = out_val_reg;
        out_status_next = out_status_reg;
        in_ready        = 1'b0;
        rf_rd_en        = 1'b0;
        rf_wr_en        = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (instr.valid)
                begin
                    instr_next = instr.instruction;
                    rf_rd_en   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                // writes to register zero are dropped and reported as no write
                res_npc_next    = ex_npc;
                res_status_next = ex_status;
                res_wr_next     = ex_wr && (ex_rd != '0);
                res_idx_next    = (ex_wr && (ex_rd != '0)) ? ex_rd : '0;
                res_val_next    = (ex_wr && (ex_rd != '0)) ? ex_val : '0;
                state_next      = ex_md_go ? CS_MULDIV : CS_COMMIT;
            end
            CS_MULDIV:
            begin
                if (md_done)
                begin
                    hi_next    = md_hi;
                    lo_next    = md_lo;
                    state_next = CS_COMMIT;
                end
            end
            CS_COMMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    rf_wr_en        = res_wr_reg;
                    pc_next         = res_npc_reg;
                    out_valid_next  = 1'b1;
                    out_npc_next    = res_npc_reg;
                    out_wr_next     = res_wr_reg;
                    out_idx_next    = res_idx_reg;
                    out_val_next    = res_val_reg;
                    out_status_next = res_status_reg;
                    state_next      = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign instr.ready        = in_ready;
    assign result.valid       = out_valid_reg;
    assign result.next_pc     = out_npc_reg;
    assign result.reg_write   = out_wr_reg;
    assign result.write_index = out_idx_reg;
    assign result.write_value = out_val_reg;
    assign result.status      = out_status_reg;

    `MRE_ASSERT_NEXT(a_rf_write_result, clk, rst_n, rf_wr_en, out_valid_reg && out_wr_reg)
    `MRE_ASSERT_NEXT(a_accept_exec, clk, rst_n, instr.valid && instr.ready,
        state_reg == CS_EXEC)
    `MRE_ASSERT_IMPL(a_md_done_state, clk, rst_n, md_done, state_reg == CS_MULDIV)
    `MRE_ASSERT_IMPL(a_write_index_nonzero, clk, rst_n, result.valid && result.reg_write,
        result.write_index != '0)

endmodule
